// File: src/p1305_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p1305_pkg
// Shared types and constants for the Poly1305 authenticator engine.
// ----------------------------------------------------------------------------
package p1305_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_R_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_S_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_S_HIGH = 2'd3;

    localparam logic [63:0] CLAMP_LOW  = 64'h0FFF_FFFC_0FFF_FFFF;
    localparam logic [63:0] CLAMP_HIGH = 64'h0FFF_FFFC_0FFF_FFFC;

    // 2^130 - 5
    localparam logic [129:0] PRIME = {{127{1'b1}}, 3'b011};

    // classified block: padded 131-bit message value, absorb and finish flags
    typedef struct packed {
        logic [130:0] msg;
        logic         absorb;
        logic         fin;
    } blk_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_SUB,
        ST_TAG
    } eng_state_t;

endpackage
`default_nettype wire

// File: src/p1305_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p1305_front
// Accepts input beats, masks and pads the block, and queues it for the back.
// ----------------------------------------------------------------------------
module p1305_front #(
    parameter int QueueDepth = p1305_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [135:0]      s_tdata,
    input  wire logic              s_tlast,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output p1305_pkg::blk_t        q_item
);
    localparam int PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CW = $clog2(QueueDepth + 1);

    p1305_pkg::blk_t   mem_reg [QueueDepth];
    logic [PW-1:0]     wr_reg, rd_reg;
    logic [CW-1:0]     cnt_reg;
    logic [4:0]        nb;
    logic [127:0]      raw, mask, pad;
    p1305_pkg::blk_t   cls;
    logic              push;

    always_comb
    begin
        raw  = s_tdata[127:0];
        nb   = (s_tdata[132:128] > 5'd16) ? 5'd16 : s_tdata[132:128];
        mask = '0;
        pad  = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (5'(i) < nb)
                mask[8*i +: 8] = 8'hFF;
            if (5'(i) == nb)
                pad[8*i] = 1'b1;
        end
        cls.msg    = {2'b00, (nb == 5'd16), (raw & mask) | pad};
        cls.absorb = (nb != 5'd0);
        cls.fin    = s_tlast;
    end

    assign s_tready = (cnt_reg != CW'(QueueDepth));
    assign push     = s_tvalid && s_tready && (cls.absorb || cls.fin);
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(QueueDepth - 1)) ? '0 : wr_reg + 1'b1;
            if (q_pop)
                rd_reg <= (rd_reg == PW'(QueueDepth - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + CW'(push) - CW'(q_pop);
        end
    end
endmodule
`default_nettype wire

// File: src/p1305_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p1305_back
// Multiply-reduce sequencer: one 27x32 partial product per cycle, then
// folding of the 2^130 overflow, conditional subtract and tag output.
// ----------------------------------------------------------------------------
module p1305_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  p1305_pkg::blk_t        q_item,
    input  wire logic [127:0]      r_key,
    input  wire logic [127:0]      s_key,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [127:0]           m_tdata
);
    p1305_pkg::eng_state_t state_reg, state_next;

    logic [129:0] acc_reg, acc_next;
    logic [130:0] h_reg;
    logic [259:0] prod_reg, prod_next;
    logic [4:0]   step_reg, step_next;
    logic [1:0]   fold_reg, fold_next;
    logic         fin_reg;
    logic [127:0] tag_reg;
    logic         tvalid_reg;
    logic [127:0] rc;
    logic [2:0]   hidx;
    logic [1:0]   widx;
    logic [26:0]  hd;
    logic [31:0]  rw;
    logic [58:0]  pp;
    logic [7:0]   sh;
    logic [132:0] fsum;
    logic [130:0] sub;
    logic         load, tag_ld;

    // step walks five h digits (26,26,26,26,27 bits) by four 32-bit r words
    assign rc   = r_key & {p1305_pkg::CLAMP_HIGH, p1305_pkg::CLAMP_LOW};
    assign hidx = step_reg[4:2];
    assign widx = step_reg[1:0];
    assign hd   = (hidx == 3'd4) ? h_reg[130:104] : {1'b0, h_reg[26*hidx +: 26]};
    assign rw   = rc[32*widx +: 32];
    assign pp   = hd * rw;
    assign sh   = 8'(hidx) * 8'd26 + {1'b0, widx, 5'b0};
    assign fsum = {3'b0, prod_reg[129:0]} + 133'(prod_reg[259:130]) * 133'd5;
    assign sub  = {1'b0, acc_reg} - {1'b0, p1305_pkg::PRIME};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            p1305_pkg::ST_IDLE: if (q_valid && !tvalid_reg)
                state_next = q_item.absorb ? p1305_pkg::ST_MUL : p1305_pkg::ST_TAG;
            p1305_pkg::ST_MUL: if (step_reg == 5'd19) state_next = p1305_pkg::ST_RED;
            p1305_pkg::ST_RED: if (fold_reg == 2'd2) state_next = p1305_pkg::ST_SUB;
            p1305_pkg::ST_SUB: state_next = fin_reg ? p1305_pkg::ST_TAG : p1305_pkg::ST_IDLE;
            p1305_pkg::ST_TAG: state_next = p1305_pkg::ST_IDLE;
            default: state_next = p1305_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        load      = 1'b0;
        tag_ld    = 1'b0;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        step_next = step_reg;
        fold_next = fold_reg;
        unique case (state_reg)
            p1305_pkg::ST_IDLE:
            begin
                load      = q_valid && !tvalid_reg;
                prod_next = '0;
                step_next = '0;
                fold_next = '0;
            end
            p1305_pkg::ST_MUL:
            begin
                prod_next = prod_reg + (260'(pp) << sh);
                step_next = step_reg + 5'd1;
            end
            p1305_pkg::ST_RED:
            begin
                prod_next = {127'b0, fsum};
                fold_next = fold_reg + 2'd1;
            end
            p1305_pkg::ST_SUB:
            begin
                acc_next = sub[130] ? prod_reg[129:0] : sub[129:0];
            end
            p1305_pkg::ST_TAG:
            begin
                tag_ld   = 1'b1;
                acc_next = '0;
            end
            default: ;
        endcase
    end

    // ST_SUB: the compare runs on acc_reg, into which the folded product is
    // staged below when the last fold is done.
    assign q_pop    = load;
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tag_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            h_reg   <= q_item.msg + {1'b0, acc_reg};
            fin_reg <= q_item.fin;
        end
        if (tag_ld)
            tag_reg <= acc_reg[127:0] + s_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= p1305_pkg::ST_IDLE;
            acc_reg    <= '0;
            prod_reg   <= '0;
            step_reg   <= '0;
            fold_reg   <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prod_reg  <= prod_next;
            step_reg  <= step_next;
            fold_reg  <= fold_next;
            // after the folds, stage the value into acc before subtracting
            if (state_reg == p1305_pkg::ST_RED && fold_reg == 2'd2)
                acc_reg <= fsum[129:0];
            else
                acc_reg <= acc_next;
            if (tag_ld)
                tvalid_reg <= 1'b1;
            else if (m_tready)
                tvalid_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: src/poly1305_mac_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// poly1305_mac_engine
// Poly1305 one-time authenticator over 0..16 byte blocks.
// ----------------------------------------------------------------------------
// channel | dir | tdata / payload
// s_axis  | in  | block_low, block_high, block_bytes; tlast = last
// m_axis  | out | tag_low, tag_high
// cfg     | in  | cfg_index (0..3), cfg_data
// An absorbed block runs the 27x32 partial products (five h digits by four
// r words), 3 folds of the 2^130 overflow, one final subtract and a return
// to idle. A last block adds a tag step; a last beat with no bytes goes from
// idle straight to the tag step. Reset clears accumulator and keys.
// A two-entry queue lets input beats land while the sequencer works; the tag
// register waits for m_tready and holds off the next block until taken.
// ----------------------------------------------------------------------------
module poly1305_mac_engine #(
    parameter int QueueDepth = p1305_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,   // block_low, block_high, block_bytes, pad
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // tag_low, tag_high
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [p1305_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]  cfg_data
);
    logic [63:0]     r_lo_reg, r_hi_reg, s_lo_reg, s_hi_reg;
    logic            q_valid, q_pop;
    p1305_pkg::blk_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_lo_reg <= '0;
            r_hi_reg <= '0;
            s_lo_reg <= '0;
            s_hi_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                p1305_pkg::REG_R_LOW:  r_lo_reg <= cfg_data;
                p1305_pkg::REG_R_HIGH: r_hi_reg <= cfg_data;
                p1305_pkg::REG_S_LOW:  s_lo_reg <= cfg_data;
                p1305_pkg::REG_S_HIGH: s_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    p1305_front #(.QueueDepth(QueueDepth)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    p1305_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .r_key    ({r_hi_reg, r_lo_reg}),
        .s_key    ({s_hi_reg, s_lo_reg}),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule
`default_nettype wire
